>>> rtl/ial_pkg.sv
// Shared types and codes for the indexed array list.
package ial_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned STAT_W   = 2;
  // Positions are 6 bits wide, so only the lowest 64 cells can be addressed.
  localparam int unsigned POS_SPAN = 64;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_ERASE  = 3'd2,
    OP_WRITE  = 3'd3,
    OP_READ   = 3'd4
  } ial_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } ial_status_e;

  // Broadcast to every cell; each flag is already qualified by the checks.
  typedef struct packed {
    logic do_append;
    logic do_insert;
    logic do_erase;
    logic do_write;
  } ial_ctrl_t;

endpackage

>>> rtl/ial_if.sv
// Request and response channel interfaces of the indexed array list.
interface ial_req_if;
  logic                               valid;
  logic                               ready;
  logic [ial_pkg::OP_W-1:0]           operation;
  logic [ial_pkg::POS_W-1:0]          position;
  logic signed [ial_pkg::WORD_W-1:0]  word_in;

  modport source (output valid, operation, position, word_in, input ready);
  modport sink   (input valid, operation, position, word_in, output ready);
endinterface

interface ial_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [ial_pkg::WORD_W-1:0]  word_out;
  logic [ial_pkg::CNT_OUT_W-1:0]      entry_count;
  logic                               is_empty;
  logic [ial_pkg::STAT_W-1:0]         status;

  modport source (output valid, word_out, entry_count, is_empty, status, input ready);
  modport sink   (input valid, word_out, entry_count, is_empty, status, output ready);
endinterface

>>> rtl/ial_cell.sv
// One storage cell of the list: holds one entry, shifts to/from its neighbors.
module ial_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned KW  = 7
) (
  input  logic                              clk_i,
  input  ial_pkg::ial_ctrl_t                ctrl_i,
  input  logic [KW-1:0]                     pos_i,
  input  logic [KW-1:0]                     cnt_i,
  input  logic signed [ial_pkg::WORD_W-1:0] word_i,
  input  logic signed [ial_pkg::WORD_W-1:0] left_i,
  input  logic signed [ial_pkg::WORD_W-1:0] right_i,
  output logic signed [ial_pkg::WORD_W-1:0] data_o,
  output logic signed [ial_pkg::WORD_W-1:0] rd_o
);
  import ial_pkg::*;

  localparam logic [KW-1:0] MyIdx  = KW'(IDX);
  localparam logic [KW-1:0] NextIdx = KW'(IDX + 1);

  logic signed [WORD_W-1:0] data_q, data_d;
  logic                     hit_pos;
  logic                     hit_cnt;

  assign hit_pos = (pos_i == MyIdx);
  assign hit_cnt = (cnt_i == MyIdx);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.do_append && hit_cnt) begin
      data_d = word_i;
    end else if (ctrl_i.do_insert) begin
      if (hit_pos) begin
        data_d = word_i;
      end else if ((MyIdx > pos_i) && (MyIdx <= cnt_i)) begin
        data_d = left_i;
      end
    end else if (ctrl_i.do_erase && (MyIdx >= pos_i) && (NextIdx < cnt_i)) begin
      data_d = right_i;
    end else if (ctrl_i.do_write && hit_pos) begin
      data_d = word_i;
    end
  end

  // Payload only; contents are undefined until written.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = hit_pos ? data_q : '0;

endmodule

>>> rtl/indexed_array_list_top.sv
// Top level of the indexed array list: control, cell row and response register.
//
// Usage:
//   req_i carries one operation per request: append, insert at position,
//   erase at position, write at position or read at position, with a 32-bit
//   signed word. rsp_o returns exactly one response per request with the
//   read word (zero unless a successful read), the entry count after the
//   operation, an empty flag and a status (ok, range, full, empty).
//   Storage is a row of CAPACITY cells; every cell decides locally whether
//   to hold, load the request word, or take its left or right neighbor, so
//   insert and erase shift the entries from the position on in the same cycle.
//   The response is registered and appears in the cycle after the request
//   is accepted. Throughput: one request per cycle unless the receiver
//   stalls; the response register frees in the cycle it is taken, so
//   req_i.ready = !rsp_o.valid | rsp_o.ready. A stalled receiver holds the
//   response and blocks new requests. Reset empties the list (count
//   cleared, no response pending); cell contents are not cleared since
//   only entries below the count are ever read.
module indexed_array_list_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ial_req_if.sink    req_i,
  ial_rsp_if.source  rsp_o
);
  import ial_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = (CW > POS_W) ? CW : POS_W + 1;
  localparam int unsigned RN = (CAPACITY < POS_SPAN) ? CAPACITY : POS_SPAN;

  logic [CW-1:0]             count_q, count_d;
  logic                      rsp_valid_q;
  logic signed [WORD_W-1:0]  word_out_q, word_out_d;
  logic [CNT_OUT_W-1:0]      entry_count_q;
  logic                      is_empty_q;
  ial_status_e               status_q, status_d;

  logic                      accept;
  logic                      full;
  logic                      empty;
  logic [KW-1:0]             pos_x;
  logic [KW-1:0]             cnt_x;
  ial_ctrl_t                 ctrl;
  logic                      read_ok;
  logic signed [WORD_W-1:0]  rd_val;

  logic signed [WORD_W-1:0]  cell_data [CAPACITY];
  logic signed [WORD_W-1:0]  cell_rd   [CAPACITY];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);
  assign pos_x = KW'(req_i.position);
  assign cnt_x = KW'(count_q);

  always_comb begin
    ctrl     = '0;
    read_ok  = 1'b0;
    status_d = ST_OK;
    count_d  = count_q;
    case (req_i.operation)
      OP_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.do_append = accept;
          count_d        = count_q + 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.do_insert = accept;
          count_d        = count_q + 1'b1;
        end
      end
      OP_ERASE, OP_WRITE, OP_READ: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_d = ST_RANGE;
        end else if (req_i.operation == OP_ERASE) begin
          ctrl.do_erase = accept;
          count_d       = count_q - 1'b1;
        end else if (req_i.operation == OP_WRITE) begin
          ctrl.do_write = accept;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_inner
      assign right_w = cell_data[i+1];
    end

    ial_cell #(
      .IDX (i),
      .KW  (KW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_x),
      .cnt_i   (cnt_x),
      .word_i  (req_i.word_in),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // Each addressable cell drives zero unless it matches the position.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < RN; i++) begin
      rd_val = rd_val | cell_rd[i];
    end
  end

  assign word_out_d = read_ok ? rd_val : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_out_q    <= word_out_d;
      entry_count_q <= CNT_OUT_W'(count_d);
      is_empty_q    <= (count_d == '0);
      status_q      <= status_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.word_out    = word_out_q;
  assign rsp_o.entry_count = entry_count_q;
  assign rsp_o.is_empty    = is_empty_q;
  assign rsp_o.status      = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.operation == OP_APPEND && !full) |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not grow the list");

  a_fail_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && status_q != ST_OK) |-> word_out_q == '0)
    else $error("failed request returned data");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !accept)
    else $error("request accepted over a pending response");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the indexed array list: stimulus, list predictor and checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ial_pkg::*;

  localparam int unsigned LIST_CAP   = 64;
  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned CHUNK_LEN  = 80;
  localparam int unsigned PHASE_LEN  = 332;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
  } req_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    logic [CNT_OUT_W-1:0]     entry_count;
    logic                     is_empty;
    ial_status_e              status;
  } list_rsp_t;

  typedef enum int {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } gen_mix_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ial_req_if req_if ();
  ial_rsp_if rsp_if ();

  indexed_array_list_top #(
    .CAPACITY(LIST_CAP)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predictor state: the list as it should look after every accepted request.
  logic signed [WORD_W-1:0] list_cells [LIST_CAP];
  int unsigned              list_len = 0;
  int unsigned              list_peak = 0;

  req_item_t   pend_q [$];
  list_rsp_t   rsp_q [$];
  int unsigned gen_len;
  int          idle_pct;
  int          stall_pct;
  int unsigned err_cnt = 0;
  int unsigned req_cnt = 0;
  int unsigned stat_seen [4] = '{default: 0};

  function automatic list_rsp_t apply_to_list(req_item_t r);
    list_rsp_t   res;
    int unsigned j;
    res.word_out = '0;
    res.status   = ST_OK;
    case (r.op)
      OP_APPEND: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          list_cells[list_len] = r.word;
          list_len++;
        end
      end
      OP_INSERT: begin
        // range check wins over the full check
        if (r.pos > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          for (j = list_len; j > r.pos; j--) list_cells[j] = list_cells[j-1];
          list_cells[r.pos] = r.word;
          list_len++;
        end
      end
      OP_ERASE, OP_WRITE, OP_READ: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (r.pos >= list_len) begin
          res.status = ST_RANGE;
        end else if (r.op == OP_ERASE) begin
          for (j = 32'(r.pos); j + 1 < list_len; j++) list_cells[j] = list_cells[j+1];
          list_len--;
        end else if (r.op == OP_WRITE) begin
          list_cells[r.pos] = r.word;
        end else begin
          res.word_out = list_cells[r.pos];
        end
      end
      default: ;
    endcase
    res.entry_count = list_len[CNT_OUT_W-1:0];
    res.is_empty    = (list_len == 0);
    return res;
  endfunction

  // Queues one request; tracks the length only to steer positions into range.
  task automatic push_req(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                          logic signed [WORD_W-1:0] word);
    req_item_t r;
    r.op   = op;
    r.pos  = pos;
    r.word = word;
    pend_q = {pend_q, r};
    case (op)
      OP_APPEND: if (gen_len < LIST_CAP) gen_len++;
      OP_INSERT: if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
      OP_ERASE:  if (gen_len > 0 && pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  task automatic push_random(gen_mix_e mix);
    int                       pick;
    int unsigned              hi;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
    pick = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (pick < 50)      op = OP_APPEND;
        else if (pick < 85) op = OP_INSERT;
        else if (pick < 90) op = OP_WRITE;
        else if (pick < 95) op = OP_READ;
        else if (pick < 98) op = OP_ERASE;
        else op = OP_W'($urandom_range(int'(OP_READ) + 1, (1 << OP_W) - 1));
      end
      MIX_DRAIN: begin
        if (pick < 55)      op = OP_ERASE;
        else if (pick < 65) op = OP_APPEND;
        else if (pick < 70) op = OP_INSERT;
        else if (pick < 85) op = OP_READ;
        else if (pick < 95) op = OP_WRITE;
        else op = OP_W'($urandom_range(int'(OP_READ) + 1, (1 << OP_W) - 1));
      end
      default: begin
        if (pick < 20)      op = OP_APPEND;
        else if (pick < 40) op = OP_INSERT;
        else if (pick < 60) op = OP_ERASE;
        else if (pick < 75) op = OP_WRITE;
        else if (pick < 95) op = OP_READ;
        else op = OP_W'($urandom_range(int'(OP_READ) + 1, (1 << OP_W) - 1));
      end
    endcase
    // mostly in-range positions, the rest anywhere in the field
    if ($urandom_range(0, 9) < 8) begin
      if (op == OP_INSERT) hi = (gen_len < POS_SPAN) ? gen_len : POS_SPAN - 1;
      else                 hi = (gen_len > 0) ? gen_len - 1 : 0;
      pos = POS_W'($urandom_range(0, hi));
    end else begin
      pos = POS_W'($urandom);
    end
    case ($urandom_range(0, 19))
      0:       word = 32'sh8000_0000;
      1:       word = 32'sh7fff_ffff;
      2:       word = '0;
      3:       word = -32'sd1;
      default: word = $urandom;
    endcase
    push_req(op, pos, word);
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || req_if.valid || rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : drv_proc
    req_item_t acc;
    req_item_t nxt;
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_APPEND;
      req_if.position  <= '0;
      req_if.word_in   <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        acc.op   = req_if.operation;
        acc.pos  = req_if.position;
        acc.word = req_if.word_in;
        rsp_q = {rsp_q, apply_to_list(acc)};
        req_cnt++;
        if (list_len > list_peak) list_peak = list_len;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = pend_q.pop_front();
          req_if.valid     <= 1'b1;
          req_if.operation <= nxt.op;
          req_if.position  <= nxt.pos;
          req_if.word_in   <= nxt.word;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin : mon_proc
    list_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_q.size() == 0) begin
          $error("unexpected response: no request outstanding");
          err_cnt++;
        end else begin
          want = rsp_q.pop_front();
          stat_seen[int'(want.status)]++;
          if (rsp_if.word_out !== want.word_out) begin
            $error("word_out: expected %0d, got %0d", want.word_out, rsp_if.word_out);
            err_cnt++;
          end
          if (rsp_if.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   rsp_if.entry_count);
            err_cnt++;
          end
          if (rsp_if.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, rsp_if.is_empty);
            err_cnt++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            err_cnt++;
          end
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_proc
    int phase_idle  [4];
    int phase_stall [4];
    int unsigned n;
    phase_idle  = '{0, 66, 0, 14};
    phase_stall = '{0, 0, 66, 14};
    rst_ni    = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    gen_len   = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty-list errors, end positions, extremes, unknown codes
    push_req(OP_READ,   6'd0,  32'sd7);
    push_req(OP_ERASE,  6'd0,  32'sd0);
    push_req(OP_WRITE,  6'd5,  32'sd9);
    push_req(OP_INSERT, 6'd1,  32'sd1);
    push_req(OP_INSERT, 6'd0,  32'sh7fff_ffff);
    push_req(OP_APPEND, 6'd63, 32'sh8000_0000);
    push_req(OP_INSERT, 6'd2,  32'sd0);
    push_req(OP_INSERT, 6'd63, 32'sd3);
    push_req(OP_INSERT, 6'd1,  -32'sd1);
    push_req(OP_WRITE,  6'd0,  32'sh5a5a_5a5a);
    push_req(OP_READ,   6'd0,  32'sd0);
    push_req(OP_READ,   6'd3,  32'sd0);
    push_req(OP_READ,   6'd4,  32'sd0);
    push_req(OP_READ,   6'd63, 32'sd0);
    push_req(OP_ERASE,  6'd3,  32'sd0);
    push_req(OP_ERASE,  6'd0,  32'sd0);
    push_req(OP_ERASE,  6'd2,  32'sd0);
    push_req(OP_WRITE,  6'd1,  32'sh7fff_ffff);
    push_req(OP_READ,   6'd1,  32'sd0);
    for (int c = int'(OP_READ) + 1; c < (1 << OP_W); c++) push_req(OP_W'(c), 6'd0, 32'sh2a);
    push_req(OP_ERASE,  6'd0,  32'sd0);
    push_req(OP_ERASE,  6'd0,  32'sd0);
    push_req(OP_READ,   6'd0,  32'sd0);
    wait_drained();

    // random phases, each drained fully before the next one starts
    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (n = 0; n < PHASE_LEN; n++) push_random(gen_mix_e'((n / CHUNK_LEN) % 3));
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d requests over four idling mixes, peak list length %0d.",
             req_cnt, list_peak);
    $display("Status counts: ok %0d, range %0d, full %0d, empty %0d.",
             stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3]);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
